// File: design/ljpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_pkg
// Types, constants and arithmetic helpers shared by the pair force pipeline.
// ----------------------------------------------------------------------------
package ljpf_pkg;

  localparam int POS_W = 24;
  localparam int R2_W  = 50;
  localparam int OUT_W = 48;
  localparam int CFG_W = 48;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_X24  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd24;
  localparam logic [63:0] LIM_X4   = 64'hFFFF_FFFF_FFFF_FFFF / 64'd4;
  localparam logic [63:0] POS_MAX  = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAG  = 64'h0000_8000_0000_0000;

  typedef enum logic [1:0] {
    REG_EPSILON    = 2'd0,
    REG_SIGMA_SQ   = 2'd1,
    REG_CUTOFF_SQ  = 2'd2,
    REG_BOX_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] mag;
    logic [2:0]            neg;
    logic                  hit;
    logic [R2_W-1:0]       r2;
  } pair_side_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] mag;
    logic [2:0]            neg;
    logic                  a_neg;
    logic                  hit;
    logic [OUT_W-1:0]      energy;
  } force_side_t;

  // floor(a*b / 2^32) from four 32x32 partial products, saturating
  function automatic logic [63:0] mul64_hi(input logic [63:0] p0, input logic [63:0] p1,
                                           input logic [63:0] p2, input logic [63:0] p3);
    logic [127:0] s;
    s = {p3, p0} + {32'b0, p1, 32'b0} + {32'b0, p2, 32'b0};
    return (s[127:96] != 32'b0) ? ALL_ONES : s[95:32];
  endfunction

  function automatic logic [OUT_W-1:0] signed_out(input logic [63:0] mag, input logic neg);
    logic [63:0] m;
    logic [63:0] n;
    if (neg) begin
      m = (mag > NEG_MAG) ? NEG_MAG : mag;
      n = 64'd0 - m;
      return n[OUT_W-1:0];
    end
    m = (mag > POS_MAX) ? POS_MAX : mag;
    return m[OUT_W-1:0];
  endfunction

endpackage

// File: design/ljpf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_in_if / ljpf_out_if
// Pair input channel and force result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ljpf_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] first_x;
  logic [23:0] first_y;
  logic [23:0] first_z;
  logic [23:0] second_x;
  logic [23:0] second_y;
  logic [23:0] second_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink   (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  output ready);
endinterface

interface ljpf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] force_x;
  logic signed [47:0] force_y;
  logic signed [47:0] force_z;
  logic signed [47:0] pair_energy;
  logic               within_cutoff;

  modport source (output valid, force_x, force_y, force_z, pair_energy, within_cutoff,
                  input ready);
  modport sink   (input valid, force_x, force_y, force_z, pair_energy, within_cutoff,
                  output ready);
endinterface

// File: design/lennard_jones_pair_force_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_unit
// Lennard-Jones pair force and energy with cutoff in a cubic periodic box.
// ----------------------------------------------------------------------------
// One particle pair enters per cycle and its force/energy result leaves
// from the output register after the last stage. The pipeline depth is set
// by the two bit-serial divider pipelines, sigma^2/r^2 (80 stages) and the
// force magnitude over r^2 (64 + 2*FRACTION_BITS stages); the rest is 19
// stages of differencing, squaring, 32x32 partial products and saturation.
// When the result is not taken the whole pipeline holds and in_chan.ready
// drops; nothing is lost. Write configuration only while the pipeline is
// empty. No clearing pass after reset.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [ljpf_pkg::CFG_W-1:0] cfg_wdata,
  ljpf_in_if.sink                  in_chan,
  ljpf_out_if.source               out_chan
);
  import ljpf_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam logic [23:0] EPS_RST = 24'(64'd1 << F);
  localparam logic [47:0] SIG_RST = 48'(64'd1 << (2 * F));
  localparam logic [47:0] CUT_RST = 48'(64'd25 << (2 * F - 2));
  localparam logic [23:0] BOX_RST = 24'(64'd10 << F);

  logic [23:0] eps_r;
  logic [47:0] sig2_r;
  logic [47:0] cut2_r;
  logic [23:0] box_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= EPS_RST;
      sig2_r <= SIG_RST;
      cut2_r <= CUT_RST;
      box_r  <= BOX_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_EPSILON:    eps_r  <= cfg_wdata[23:0];
        REG_SIGMA_SQ:   sig2_r <= cfg_wdata[47:0];
        REG_CUTOFF_SQ:  cut2_r <= cfg_wdata[47:0];
        REG_BOX_LENGTH: box_r  <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_v_r;
  assign adv           = !out_v_r || out_chan.ready;
  assign in_chan.ready = adv;

  // --- separation -----------------------------------------------------------
  logic [2:0][23:0] pa, pb;
  assign pa[0] = in_chan.first_x;
  assign pa[1] = in_chan.first_y;
  assign pa[2] = in_chan.first_z;
  assign pb[0] = in_chan.second_x;
  assign pb[1] = in_chan.second_y;
  assign pb[2] = in_chan.second_z;

  logic             p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r, p6_v_r;
  logic [2:0][24:0] d1_nxt, d1_r;
  logic [2:0][25:0] d2_nxt, d2_r;
  logic [2:0][23:0] mag3_nxt, mag3_r, mag4_r, mag5_r, mag6_r;
  logic [2:0]       neg3_nxt, neg3_r, neg4_r, neg5_r, neg6_r;
  logic [2:0][47:0] sq4_nxt, sq4_r;
  logic [R2_W-1:0]  r2_5_nxt, r2_5_r, r2_6_r;
  logic             hit6_nxt, hit6_r;

  always_comb begin
    logic [25:0] dw, twice, len, nlen, t;
    for (int k = 0; k < 3; k++) begin
      d1_nxt[k] = {1'b0, pa[k]} - {1'b0, pb[k]};
      dw    = {d1_r[k][24], d1_r[k]};
      twice = {d1_r[k], 1'b0};
      len   = {2'b00, box_r};
      nlen  = 26'd0 - len;
      if ($signed(twice) > $signed(len)) begin
        d2_nxt[k] = dw - len;
      end else if ($signed(twice) < $signed(nlen)) begin
        d2_nxt[k] = dw + len;
      end else begin
        d2_nxt[k] = dw;
      end
      t           = 26'd0 - d2_r[k];
      neg3_nxt[k] = d2_r[k][25];
      mag3_nxt[k] = d2_r[k][25] ? t[23:0] : d2_r[k][23:0];
      sq4_nxt[k]  = mag3_r[k] * mag3_r[k];
    end
    r2_5_nxt = {2'b00, sq4_r[0]} + {2'b00, sq4_r[1]} + {2'b00, sq4_r[2]};
    hit6_nxt = (r2_5_r != '0) && (r2_5_r <= {2'b00, cut2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
      p6_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= in_chan.valid;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      p5_v_r <= p4_v_r;
      p6_v_r <= p5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      mag3_r <= mag3_nxt;
      neg3_r <= neg3_nxt;
      sq4_r  <= sq4_nxt;
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;
      r2_5_r <= r2_5_nxt;
      mag5_r <= mag4_r;
      neg5_r <= neg4_r;
      hit6_r <= hit6_nxt;
      r2_6_r <= r2_5_r;
      mag6_r <= mag5_r;
      neg6_r <= neg5_r;
    end
  end

  // --- sigma^2 / r^2 --------------------------------------------------------
  pair_side_t side6, q_side;
  logic       q_v;
  logic [63:0] q_quo;

  assign side6.mag = mag6_r;
  assign side6.neg = neg6_r;
  assign side6.hit = hit6_r;
  assign side6.r2  = r2_6_r;

  ljpf_div #(
    .NUM_W (48),
    .DEN_W (R2_W),
    .SHIFT (32),
    .SIDE_W($bits(pair_side_t))
  ) u_div_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (p6_v_r),
    .in_num   (sig2_r),
    .in_den   (r2_6_r),
    .in_side  (side6),
    .out_valid(q_v),
    .out_quo  (q_quo),
    .out_side (q_side)
  );

  // --- powers and sign/magnitude terms --------------------------------------
  logic             q1_v_r, q2_v_r, q3_v_r, q4_v_r, q5_v_r, q6_v_r, q7_v_r;
  pair_side_t       q1_s_r, q2_s_r, q3_s_r, q4_s_r, q5_s_r, q6_s_r, q7_s_r;
  logic [63:0]      q1_q_r, q2_q_r;
  logic [3:0][63:0] q1_pp_nxt, q1_pp_r, q3_pp_nxt, q3_pp_r, q5_pp_nxt, q5_pp_r;
  logic [63:0]      q2_qq_r, q4_s6_r, q5_s6_r, q6_s6_r, q6_s12_r;
  logic [63:0]      a7_nxt, b7_nxt, a7_r, b7_r;
  logic             an7_nxt, bn7_nxt, an7_r, bn7_r;

  always_comb begin
    logic [63:0] gap;
    q1_pp_nxt[0] = q_quo[31:0] * q_quo[31:0];
    q1_pp_nxt[1] = q_quo[31:0] * q_quo[63:32];
    q1_pp_nxt[2] = q_quo[63:32] * q_quo[31:0];
    q1_pp_nxt[3] = q_quo[63:32] * q_quo[63:32];
    q3_pp_nxt[0] = q2_qq_r[31:0] * q2_q_r[31:0];
    q3_pp_nxt[1] = q2_qq_r[31:0] * q2_q_r[63:32];
    q3_pp_nxt[2] = q2_qq_r[63:32] * q2_q_r[31:0];
    q3_pp_nxt[3] = q2_qq_r[63:32] * q2_q_r[63:32];
    q5_pp_nxt[0] = q4_s6_r[31:0] * q4_s6_r[31:0];
    q5_pp_nxt[1] = q4_s6_r[31:0] * q4_s6_r[63:32];
    q5_pp_nxt[2] = q4_s6_r[63:32] * q4_s6_r[31:0];
    q5_pp_nxt[3] = q4_s6_r[63:32] * q4_s6_r[63:32];
    gap = q6_s6_r - q6_s12_r;
    if (q6_s12_r >= q6_s6_r) begin
      bn7_nxt = 1'b0;
      an7_nxt = 1'b0;
      b7_nxt  = q6_s12_r - q6_s6_r;
      a7_nxt  = (b7_nxt > ~q6_s12_r) ? ALL_ONES : q6_s12_r + b7_nxt;
    end else begin
      bn7_nxt = 1'b1;
      b7_nxt  = gap;
      an7_nxt = gap > q6_s12_r;
      a7_nxt  = an7_nxt ? gap - q6_s12_r : q6_s12_r - gap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= 1'b0;
      q2_v_r <= 1'b0;
      q3_v_r <= 1'b0;
      q4_v_r <= 1'b0;
      q5_v_r <= 1'b0;
      q6_v_r <= 1'b0;
      q7_v_r <= 1'b0;
    end else if (adv) begin
      q1_v_r <= q_v;
      q2_v_r <= q1_v_r;
      q3_v_r <= q2_v_r;
      q4_v_r <= q3_v_r;
      q5_v_r <= q4_v_r;
      q6_v_r <= q5_v_r;
      q7_v_r <= q6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_s_r   <= q_side;
      q1_q_r   <= q_quo;
      q1_pp_r  <= q1_pp_nxt;
      q2_s_r   <= q1_s_r;
      q2_q_r   <= q1_q_r;
      q2_qq_r  <= mul64_hi(q1_pp_r[0], q1_pp_r[1], q1_pp_r[2], q1_pp_r[3]);
      q3_s_r   <= q2_s_r;
      q3_pp_r  <= q3_pp_nxt;
      q4_s_r   <= q3_s_r;
      q4_s6_r  <= mul64_hi(q3_pp_r[0], q3_pp_r[1], q3_pp_r[2], q3_pp_r[3]);
      q5_s_r   <= q4_s_r;
      q5_s6_r  <= q4_s6_r;
      q5_pp_r  <= q5_pp_nxt;
      q6_s_r   <= q5_s_r;
      q6_s6_r  <= q5_s6_r;
      q6_s12_r <= mul64_hi(q5_pp_r[0], q5_pp_r[1], q5_pp_r[2], q5_pp_r[3]);
      q7_s_r   <= q6_s_r;
      a7_r     <= a7_nxt;
      b7_r     <= b7_nxt;
      an7_r    <= an7_nxt;
      bn7_r    <= bn7_nxt;
    end
  end

  // --- epsilon scaling ------------------------------------------------------
  logic        e1_v_r, e2_v_r, e3_v_r;
  pair_side_t  e1_s_r, e2_s_r, e3_s_r;
  logic        e1_an_r, e1_bn_r, e2_an_r, e2_bn_r, e3_an_r;
  logic [55:0] e1_alo_r, e1_ahi_r, e1_blo_r, e1_bhi_r;
  logic [63:0] e2_a_nxt, e2_b_nxt, e2_a_r, e2_b_r;
  logic [63:0] e3_fr_nxt, e3_fr_r;
  logic [OUT_W-1:0] e3_en_nxt, e3_en_r;

  always_comb begin
    logic [87:0] sa, sb;
    logic [63:0] ev;
    sa = ({e1_ahi_r, 32'b0} + {32'b0, e1_alo_r}) >> F;
    sb = ({e1_bhi_r, 32'b0} + {32'b0, e1_blo_r}) >> F;
    e2_a_nxt  = (sa[87:64] != '0) ? ALL_ONES : sa[63:0];
    e2_b_nxt  = (sb[87:64] != '0) ? ALL_ONES : sb[63:0];
    e3_fr_nxt = (e2_a_r > LIM_X24) ? ALL_ONES : {e2_a_r[59:0], 4'b0} + {e2_a_r[60:0], 3'b0};
    ev        = (e2_b_r > LIM_X4) ? ALL_ONES : {e2_b_r[61:0], 2'b0};
    e3_en_nxt = signed_out({8'b0, ev[63:8]}, e2_bn_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
    end else if (adv) begin
      e1_v_r <= q7_v_r;
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_s_r   <= q7_s_r;
      e1_an_r  <= an7_r;
      e1_bn_r  <= bn7_r;
      e1_alo_r <= a7_r[31:0] * eps_r;
      e1_ahi_r <= a7_r[63:32] * eps_r;
      e1_blo_r <= b7_r[31:0] * eps_r;
      e1_bhi_r <= b7_r[63:32] * eps_r;
      e2_s_r   <= e1_s_r;
      e2_an_r  <= e1_an_r;
      e2_bn_r  <= e1_bn_r;
      e2_a_r   <= e2_a_nxt;
      e2_b_r   <= e2_b_nxt;
      e3_s_r   <= e2_s_r;
      e3_an_r  <= e2_an_r;
      e3_fr_r  <= e3_fr_nxt;
      e3_en_r  <= e3_en_nxt;
    end
  end

  // --- force magnitude over r^2 ---------------------------------------------
  force_side_t side_e3, f_side;
  logic        f_v;
  logic [63:0] f_quo;

  assign side_e3.mag    = e3_s_r.mag;
  assign side_e3.neg    = e3_s_r.neg;
  assign side_e3.a_neg  = e3_an_r;
  assign side_e3.hit    = e3_s_r.hit;
  assign side_e3.energy = e3_en_r;

  ljpf_div #(
    .NUM_W (64),
    .DEN_W (R2_W),
    .SHIFT (2 * F),
    .SIDE_W($bits(force_side_t))
  ) u_div_f (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (e3_v_r),
    .in_num   (e3_fr_r),
    .in_den   (e3_s_r.r2),
    .in_side  (side_e3),
    .out_valid(f_v),
    .out_quo  (f_quo),
    .out_side (f_side)
  );

  // --- force components and output register ---------------------------------
  logic             f1_v_r, f2_v_r;
  force_side_t      f1_s_r, f2_s_r;
  logic [2:0][55:0] f1_lo_r, f1_hi_r;
  logic [2:0][63:0] f2_c_nxt, f2_c_r;
  logic [2:0][OUT_W-1:0] o_f_nxt, o_f_r;
  logic [OUT_W-1:0] o_e_r;
  logic             o_hit_r;

  always_comb begin
    logic [87:0] s;
    for (int k = 0; k < 3; k++) begin
      s           = ({f1_hi_r[k], 32'b0} + {32'b0, f1_lo_r[k]}) >> (F + 8);
      f2_c_nxt[k] = (s[87:64] != '0) ? ALL_ONES : s[63:0];
      o_f_nxt[k]  = f2_s_r.hit ? signed_out(f2_c_r[k], f2_s_r.a_neg ^ f2_s_r.neg[k]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r  <= 1'b0;
      f2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r  <= f_v;
      f2_v_r  <= f1_v_r;
      out_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_s_r <= f_side;
      for (int k = 0; k < 3; k++) begin
        f1_lo_r[k] <= f_quo[31:0] * f_side.mag[k];
        f1_hi_r[k] <= f_quo[63:32] * f_side.mag[k];
      end
      f2_s_r  <= f1_s_r;
      f2_c_r  <= f2_c_nxt;
      o_f_r   <= o_f_nxt;
      o_e_r   <= f2_s_r.hit ? f2_s_r.energy : '0;
      o_hit_r <= f2_s_r.hit;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.force_x       = o_f_r[0];
  assign out_chan.force_y       = o_f_r[1];
  assign out_chan.force_z       = o_f_r[2];
  assign out_chan.pair_energy   = o_e_r;
  assign out_chan.within_cutoff = o_hit_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.within_cutoff |->
      out_chan.force_x == '0 && out_chan.force_y == '0 &&
      out_chan.force_z == '0 && out_chan.pair_energy == '0)
    else $error("non-interacting pair gave nonzero force or energy");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |-> !in_chan.ready)
    else $error("transaction accepted while pipeline is held");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

endmodule

// File: design/ljpf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_div
// Pipelined restoring divider, one quotient bit per stage: floor(num*2^SHIFT
// / den), saturated to all ones. A side word travels with each operand pair.
// ----------------------------------------------------------------------------
module ljpf_div #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 50,
  parameter int SHIFT  = 32,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [63:0]       out_quo,
  output logic [SIDE_W-1:0] out_side
);
  localparam int STEPS = NUM_W + SHIFT;

  logic              v_r    [STEPS];
  logic [NUM_W-1:0]  num_r  [STEPS];
  logic [DEN_W-1:0]  den_r  [STEPS];
  logic [DEN_W-1:0]  rem_r  [STEPS];
  logic [63:0]       q_r    [STEPS];
  logic              ovf_r  [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic              v_in;
    logic [NUM_W-1:0]  num_in;
    logic [DEN_W-1:0]  den_in;
    logic [DEN_W-1:0]  rem_in;
    logic [63:0]       q_in;
    logic              ovf_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign num_in  = in_num;
      assign den_in  = in_den;
      assign rem_in  = '0;
      assign q_in    = '0;
      assign ovf_in  = 1'b0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign num_in  = num_r[i-1];
      assign den_in  = den_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign q_in    = q_r[i-1];
      assign ovf_in  = ovf_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[i]  <= {num_in[NUM_W-2:0], 1'b0};
        den_r[i]  <= den_in;
        rem_r[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q_r[i]    <= {q_in[62:0], ge};
        ovf_r[i]  <= ovf_in | q_in[63];
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_quo   = ovf_r[STEPS-1] ? '1 : q_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule
